FILE: design/bis_pkg.sv
`default_nettype none
package bis_pkg;

   localparam int COL_BITS       = 10;
   localparam int ROW_BITS       = 9;
   localparam int FRAC_BITS      = 8;
   localparam int PIXEL_BITS     = 8;
   localparam int VALUE_BITS     = 16;
   localparam int OUT_FRAC       = 8;
   localparam int OUT_SHIFT      = 2 * FRAC_BITS - OUT_FRAC;

   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 10;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 1;

   localparam int QX_BITS        = COL_BITS + FRAC_BITS;
   localparam int QY_BITS        = ROW_BITS + FRAC_BITS;

   localparam int WEIGHT_BITS    = FRAC_BITS + 1;
   localparam int WPROD_BITS     = 2 * FRAC_BITS + 1;
   localparam int TERM_BITS      = WPROD_BITS + PIXEL_BITS;
   localparam int ACC_BITS       = TERM_BITS + 2;

   localparam int BANK_COL_BITS  = COL_BITS - 1;
   localparam int BANK_ROW_BITS  = ROW_BITS - 1;
   localparam int BANK_ADDR_BITS = BANK_COL_BITS + BANK_ROW_BITS;
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
   localparam int NUM_BANKS      = 4;
   localparam int BANK_SEL_BITS  = 2;

   localparam logic [WIDTH_BITS-1:0]  MAX_COLS     = WIDTH_BITS'(1 << COL_BITS);
   localparam logic [HEIGHT_BITS-1:0] MAX_ROWS     = HEIGHT_BITS'(1 << ROW_BITS);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 10'd480;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE   = WEIGHT_BITS'(1 << FRAC_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [COL_BITS-1:0]   load_col;
      logic [ROW_BITS-1:0]   load_row;
      logic [PIXEL_BITS-1:0] pixel_value;
      logic [QX_BITS-1:0]    query_x;
      logic [QY_BITS-1:0]    query_y;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] interp_value;
      logic                  out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] p00;
      logic [PIXEL_BITS-1:0] p10;
      logic [PIXEL_BITS-1:0] p01;
      logic [PIXEL_BITS-1:0] p11;
   } quad_type;

   typedef struct packed {
      logic                 valid;
      logic                 oor;
      logic [FRAC_BITS-1:0] wx1;
      logic [FRAC_BITS-1:0] wy1;
   } ctl_type;

endpackage
`default_nettype wire

FILE: design/bilinear_image_sampler_top.sv
// A query result is on rsp_ for one cycle, after the store read and blend stages a, b, rsp.
// Throughput: one transaction per cycle while not busy, load or query; four parity banks of the
// frame store give all four neighbours in one read; the blend is a three-stage multiply-add.
// Reset: synchronous, clears the pipeline valids, sets image size to 640 x 480 and holds busy
// for one cycle after release; frame store contents are not cleared.
// The receiver cannot stall; loads give no result.
`default_nettype none
module bilinear_image_sampler_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  bis_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output bis_pkg::rsp_type                   rsp_data,
   input  wire                                csr_wr_en,
   input  wire  [bis_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [bis_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);
   import bis_pkg::*;

   logic                    busy_ff;
   logic [WIDTH_BITS-1:0]   width_ff;
   logic [HEIGHT_BITS-1:0]  height_ff;
   logic                    accept;
   logic                    query;
   logic                    load;
   logic [COL_BITS-1:0]     x0;
   logic [ROW_BITS-1:0]     y0;
   logic [WIDTH_BITS-1:0]   x1;
   logic [HEIGHT_BITS-1:0]  y1;
   logic [WIDTH_BITS-1:0]   width_sat;
   logic [HEIGHT_BITS-1:0]  height_sat;
   ctl_type                 s1_ctl_in;
   ctl_type                 s1_ctl_ff;
   quad_type                s1_quad;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data[WIDTH_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data[HEIGHT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;
   assign query  = accept && (req_data.cmd == CMD_QUERY);
   assign load   = accept && (req_data.cmd == CMD_LOAD);

   assign x0 = req_data.query_x[FRAC_BITS +: COL_BITS];
   assign y0 = req_data.query_y[FRAC_BITS +: ROW_BITS];
   assign x1 = WIDTH_BITS'(x0) + WIDTH_BITS'(1);
   assign y1 = HEIGHT_BITS'(y0) + HEIGHT_BITS'(1);

   // saturate oversized image dimensions to the store size
   assign width_sat  = (width_ff > MAX_COLS) ? MAX_COLS : width_ff;
   assign height_sat = (height_ff > MAX_ROWS) ? MAX_ROWS : height_ff;

   always_comb begin
      s1_ctl_in.valid = query;
      s1_ctl_in.oor   = (x1 >= width_sat) || (y1 >= height_sat);
      s1_ctl_in.wx1   = req_data.query_x[FRAC_BITS-1:0];
      s1_ctl_in.wy1   = req_data.query_y[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
      end else begin
         s1_ctl_ff.valid <= s1_ctl_in.valid;
      end
      s1_ctl_ff.oor <= s1_ctl_in.oor;
      s1_ctl_ff.wx1 <= s1_ctl_in.wx1;
      s1_ctl_ff.wy1 <= s1_ctl_in.wy1;
   end

   bis_frame_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load),
      .wr_col   (req_data.load_col),
      .wr_row   (req_data.load_row),
      .wr_pixel (req_data.pixel_value),
      .rd_en    (query),
      .rd_x0    (x0),
      .rd_y0    (y0),
      .quad     (s1_quad)
   );

   bis_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .ctl       (s1_ctl_ff),
      .quad      (s1_quad),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_query_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_QUERY) |=> ##3 rsp_valid)
      else $error("query transaction produced no result");

   a_load_gives_none: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_LOAD) |=> ##3 !rsp_valid)
      else $error("load transaction produced a result");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.interp_value == '0))
      else $error("out-of-range result carries a non-zero value");

endmodule
`default_nettype wire

FILE: design/bis_frame_bank.sv
`default_nettype none
module bis_frame_bank (
   input  wire                                 clock,
   input  wire                                 wr_en,
   input  wire  [bis_pkg::BANK_ADDR_BITS-1:0]  wr_addr,
   input  wire  [bis_pkg::PIXEL_BITS-1:0]      wr_data,
   input  wire                                 rd_en,
   input  wire  [bis_pkg::BANK_ADDR_BITS-1:0]  rd_addr,
   output logic [bis_pkg::PIXEL_BITS-1:0]      rd_data
);
   import bis_pkg::*;

   logic [PIXEL_BITS-1:0] mem [BANK_DEPTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/bis_frame_store.sv
`default_nettype none
module bis_frame_store (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            wr_en,
   input  wire  [bis_pkg::COL_BITS-1:0]   wr_col,
   input  wire  [bis_pkg::ROW_BITS-1:0]   wr_row,
   input  wire  [bis_pkg::PIXEL_BITS-1:0] wr_pixel,
   input  wire                            rd_en,
   input  wire  [bis_pkg::COL_BITS-1:0]   rd_x0,
   input  wire  [bis_pkg::ROW_BITS-1:0]   rd_y0,
   output bis_pkg::quad_type              quad
);
   import bis_pkg::*;

   logic [COL_BITS:0]             x0_inc;
   logic [ROW_BITS:0]             y0_inc;
   logic [BANK_COL_BITS-1:0]      col_even;
   logic [BANK_COL_BITS-1:0]      col_odd;
   logic [BANK_ROW_BITS-1:0]      row_even;
   logic [BANK_ROW_BITS-1:0]      row_odd;
   logic [BANK_ADDR_BITS-1:0]     wr_addr;
   logic [BANK_SEL_BITS-1:0]      wr_bank;
   logic [NUM_BANKS-1:0]          bank_wr_en;
   logic [BANK_ADDR_BITS-1:0]     bank_rd_addr [NUM_BANKS];
   logic [PIXEL_BITS-1:0]         bank_data [NUM_BANKS];
   logic                          px_ff;
   logic                          py_ff;

   // even-parity neighbour sits at (v+1)>>1, odd-parity one at v>>1
   assign x0_inc   = {1'b0, rd_x0} + (COL_BITS + 1)'(1);
   assign y0_inc   = {1'b0, rd_y0} + (ROW_BITS + 1)'(1);
   assign col_even = x0_inc[COL_BITS-1:1];
   assign col_odd  = rd_x0[COL_BITS-1:1];
   assign row_even = y0_inc[ROW_BITS-1:1];
   assign row_odd  = rd_y0[ROW_BITS-1:1];

   assign wr_addr  = {wr_row[ROW_BITS-1:1], wr_col[COL_BITS-1:1]};
   assign wr_bank  = {wr_row[0], wr_col[0]};

   always_comb begin
      for (int b = 0; b < NUM_BANKS; b++) begin
         bank_wr_en[b]   = wr_en && (wr_bank == BANK_SEL_BITS'(b));
         bank_rd_addr[b] = {(b[1] ? row_odd : row_even), (b[0] ? col_odd : col_even)};
      end
   end

   for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
      bis_frame_bank u_bank (
         .clock   (clock),
         .wr_en   (bank_wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data (wr_pixel),
         .rd_en   (rd_en),
         .rd_addr (bank_rd_addr[g]),
         .rd_data (bank_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= 1'b0;
         py_ff <= 1'b0;
      end else if (rd_en) begin
         px_ff <= rd_x0[0];
         py_ff <= rd_y0[0];
      end
   end

   // route banks to neighbours by the parity of the upper-left corner
   always_comb begin
      quad.p00 = bank_data[{py_ff,  px_ff}];
      quad.p10 = bank_data[{py_ff,  ~px_ff}];
      quad.p01 = bank_data[{~py_ff, px_ff}];
      quad.p11 = bank_data[{~py_ff, ~px_ff}];
   end

endmodule
`default_nettype wire

FILE: design/bis_blend.sv
`default_nettype none
module bis_blend (
   input  wire                clock,
   input  wire                reset,
   input  bis_pkg::ctl_type   ctl,
   input  bis_pkg::quad_type  quad,
   output logic               rsp_valid,
   output bis_pkg::rsp_type   rsp_data
);
   import bis_pkg::*;

   logic [WEIGHT_BITS-1:0]   wx0;
   logic [WEIGHT_BITS-1:0]   wx1;
   logic [WEIGHT_BITS-1:0]   wy0;
   logic [WEIGHT_BITS-1:0]   wy1;
   logic [2*WEIGHT_BITS-1:0] m00;
   logic [2*WEIGHT_BITS-1:0] m10;
   logic [2*WEIGHT_BITS-1:0] m01;
   logic [2*WEIGHT_BITS-1:0] m11;

   logic                     a_valid_ff;
   logic                     a_oor_ff;
   logic [WPROD_BITS-1:0]    a_w00_ff, a_w10_ff, a_w01_ff, a_w11_ff;
   quad_type                 a_pix_ff;

   logic                     b_valid_ff;
   logic                     b_oor_ff;
   logic [TERM_BITS-1:0]     b_t00_in, b_t10_in, b_t01_in, b_t11_in;
   logic [TERM_BITS-1:0]     b_t00_ff, b_t10_ff, b_t01_ff, b_t11_ff;

   logic [ACC_BITS-1:0]      acc;
   rsp_type                  rsp_data_in;
   rsp_type                  rsp_data_ff;
   logic                     rsp_valid_ff;

   assign wx1 = {1'b0, ctl.wx1};
   assign wy1 = {1'b0, ctl.wy1};
   assign wx0 = WEIGHT_ONE - wx1;
   assign wy0 = WEIGHT_ONE - wy1;
   assign m00 = wx0 * wy0;
   assign m10 = wx1 * wy0;
   assign m01 = wx0 * wy1;
   assign m11 = wx1 * wy1;

   always_ff @(posedge clock) begin
      a_w00_ff <= m00[WPROD_BITS-1:0];
      a_w10_ff <= m10[WPROD_BITS-1:0];
      a_w01_ff <= m01[WPROD_BITS-1:0];
      a_w11_ff <= m11[WPROD_BITS-1:0];
      a_pix_ff <= quad;
      a_oor_ff <= ctl.oor;
   end

   assign b_t00_in = TERM_BITS'(a_w00_ff) * TERM_BITS'(a_pix_ff.p00);
   assign b_t10_in = TERM_BITS'(a_w10_ff) * TERM_BITS'(a_pix_ff.p10);
   assign b_t01_in = TERM_BITS'(a_w01_ff) * TERM_BITS'(a_pix_ff.p01);
   assign b_t11_in = TERM_BITS'(a_w11_ff) * TERM_BITS'(a_pix_ff.p11);

   always_ff @(posedge clock) begin
      b_t00_ff <= b_t00_in;
      b_t10_ff <= b_t10_in;
      b_t01_ff <= b_t01_in;
      b_t11_ff <= b_t11_in;
      b_oor_ff <= a_oor_ff;
   end

   always_comb begin
      acc = ACC_BITS'(b_t00_ff) + ACC_BITS'(b_t10_ff)
          + ACC_BITS'(b_t01_ff) + ACC_BITS'(b_t11_ff);
      rsp_data_in.out_of_range = b_oor_ff;
      rsp_data_in.interp_value = b_oor_ff ? '0 : acc[OUT_SHIFT +: VALUE_BITS];
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= ctl.valid;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: test/testbench.sv
module testbench;
   import bis_pkg::*;

   localparam int STORE_DEPTH   = 1 << (COL_BITS + ROW_BITS);
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 6;
   localparam int FRAC_MASK     = (1 << FRAC_BITS) - 1;
   localparam int PRINT_LIMIT   = 50;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   req_type                   req_data;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;

   bit [PIXEL_BITS-1:0]       pixel_mem [STORE_DEPTH];
   bit                        loaded_map [STORE_DEPTH];
   logic [WIDTH_BITS-1:0]     model_width;
   logic [HEIGHT_BITS-1:0]    model_height;
   rsp_type                   pending_blends [$];
   rsp_type                   oldest_blend;
   int                        blends_seen;
   int                        mismatch_count;
   int                        items_sent;
   int                        plan_width  = int'(WIDTH_RESET);
   int                        plan_height = int'(HEIGHT_RESET);
   int                        hot_col;
   int                        hot_row;
   bit                        burst_mode;

   bilinear_image_sampler_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endtask

   function automatic rsp_type blend_query(input req_type r);
      int      w;
      int      h;
      int      x0;
      int      y0;
      int      base;
      longint  wx1;
      longint  wy1;
      longint  wx0;
      longint  wy0;
      longint  acc;
      rsp_type res;
      w  = (model_width > MAX_COLS) ? int'(MAX_COLS) : int'(model_width);
      h  = (model_height > MAX_ROWS) ? int'(MAX_ROWS) : int'(model_height);
      x0 = int'(r.query_x >> FRAC_BITS);
      y0 = int'(r.query_y >> FRAC_BITS);
      res = '0;
      if (x0 + 1 >= w || y0 + 1 >= h) begin
         res.out_of_range = 1'b1;
         return res;
      end
      wx1  = longint'(r.query_x[FRAC_BITS-1:0]);
      wy1  = longint'(r.query_y[FRAC_BITS-1:0]);
      wx0  = longint'(WEIGHT_ONE) - wx1;
      wy0  = longint'(WEIGHT_ONE) - wy1;
      base = (y0 << COL_BITS) + x0;
      acc  = wx0 * wy0 * longint'(pixel_mem[base])
           + wx1 * wy0 * longint'(pixel_mem[base + 1])
           + wx0 * wy1 * longint'(pixel_mem[base + (1 << COL_BITS)])
           + wx1 * wy1 * longint'(pixel_mem[base + (1 << COL_BITS) + 1]);
      res.interp_value = VALUE_BITS'(acc >> OUT_SHIFT);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         model_width  = WIDTH_RESET;
         model_height = HEIGHT_RESET;
         pending_blends.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (pending_blends.size() == 0) begin
               report_mismatch($sformatf("result %h with no query waiting", rsp_data));
            end else begin
               oldest_blend = pending_blends.pop_front();
               if (rsp_data.interp_value !== oldest_blend.interp_value) begin
                  report_mismatch($sformatf("query %0d: interp_value %h, expected %h",
                     blends_seen, rsp_data.interp_value, oldest_blend.interp_value));
               end
               if (rsp_data.out_of_range !== oldest_blend.out_of_range) begin
                  report_mismatch($sformatf("query %0d: out_of_range %b, expected %b",
                     blends_seen, rsp_data.out_of_range, oldest_blend.out_of_range));
               end
            end
            blends_seen++;
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid unknown");
         end
         if (start && !busy) begin
            if (req_data.cmd == CMD_LOAD) begin
               pixel_mem[{req_data.load_row, req_data.load_col}] = req_data.pixel_value;
            end else begin
               pending_blends.push_back(blend_query(req_data));
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               model_width = csr_wr_data;
            end else begin
               model_height = csr_wr_data[HEIGHT_BITS-1:0];
            end
         end
      end
   end

   function automatic req_type random_item();
      req_type r;
      r.cmd         = 1'($urandom);
      r.load_col    = COL_BITS'($urandom);
      r.load_row    = ROW_BITS'($urandom);
      r.pixel_value = PIXEL_BITS'($urandom);
      r.query_x     = QX_BITS'($urandom);
      r.query_y     = QY_BITS'($urandom);
      return r;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      if ($urandom_range(0, 19) == 0) begin
         burst_mode = !burst_mode;
      end
      gap = burst_mode ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic load_pixel(input int col, input int row, input logic [PIXEL_BITS-1:0] pix);
      req_type r;
      r             = random_item();
      r.cmd         = CMD_LOAD;
      r.load_col    = COL_BITS'(col);
      r.load_row    = ROW_BITS'(row);
      r.pixel_value = pix;
      loaded_map[(row << COL_BITS) + col] = 1'b1;
      send_item(r);
   endtask

   task automatic query_at(input int qx, input int qy);
      req_type r;
      r         = random_item();
      r.cmd     = CMD_QUERY;
      r.query_x = QX_BITS'(qx);
      r.query_y = QY_BITS'(qy);
      send_item(r);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_blends.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input int value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= CSR_DATA_BITS'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) begin
         plan_width = value & ((1 << WIDTH_BITS) - 1);
         if (plan_width > int'(MAX_COLS)) plan_width = int'(MAX_COLS);
      end else begin
         plan_height = value & ((1 << HEIGHT_BITS) - 1);
         if (plan_height > int'(MAX_ROWS)) plan_height = int'(MAX_ROWS);
      end
   endtask

   task automatic set_geometry(input int w, input int h);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   // push a coordinate outside the image unless all four neighbours hold data
   task automatic outside_query();
      int qx;
      int qy;
      int x0;
      int y0;
      int base;
      qx = $urandom_range(0, (1 << QX_BITS) - 1);
      qy = $urandom_range(0, (1 << QY_BITS) - 1);
      x0 = qx >> FRAC_BITS;
      y0 = qy >> FRAC_BITS;
      if (x0 + 1 < plan_width && y0 + 1 < plan_height) begin
         base = (y0 << COL_BITS) + x0;
         if (!(loaded_map[base] && loaded_map[base + 1] && loaded_map[base + (1 << COL_BITS)]
               && loaded_map[base + (1 << COL_BITS) + 1])) begin
            if ($urandom_range(0, 1)) begin
               qx = ($urandom_range(plan_width - 1, (1 << COL_BITS) - 1) << FRAC_BITS)
                  | (qx & FRAC_MASK);
            end else begin
               qy = ($urandom_range(plan_height - 1, (1 << ROW_BITS) - 1) << FRAC_BITS)
                  | (qy & FRAC_MASK);
            end
         end
      end
      query_at(qx, qy);
   endtask

   // fill any missing neighbours, sometimes overwrite, then query inside the square
   task automatic blend_sequence();
      int x0;
      int y0;
      if (plan_width < 2 || plan_height < 2) begin
         outside_query();
         return;
      end
      x0 = $urandom_range(0, 1) ? hot_col + int'($urandom_range(0, 7))
                                : int'($urandom_range(0, plan_width - 2));
      y0 = $urandom_range(0, 1) ? hot_row + int'($urandom_range(0, 7))
                                : int'($urandom_range(0, plan_height - 2));
      if ($urandom_range(0, 7) == 0) x0 = plan_width - 2;
      if ($urandom_range(0, 7) == 0) y0 = plan_height - 2;
      if (x0 > plan_width - 2) x0 = plan_width - 2;
      if (y0 > plan_height - 2) y0 = plan_height - 2;
      for (int dy = 0; dy < 2; dy++) begin
         for (int dx = 0; dx < 2; dx++) begin
            if (!loaded_map[((y0 + dy) << COL_BITS) + x0 + dx] || $urandom_range(0, 3) == 0) begin
               load_pixel(x0 + dx, y0 + dy, random_pixel());
            end
         end
      end
      query_at((x0 << FRAC_BITS) + int'($urandom_range(0, FRAC_MASK)),
               (y0 << FRAC_BITS) + int'($urandom_range(0, FRAC_MASK)));
   endtask

   task automatic run_phase(input int w, input int h);
      int stop_at;
      int pick;
      set_geometry(w, h);
      hot_col = $urandom_range(0, plan_width >= 2 ? plan_width - 2 : 0);
      hot_row = $urandom_range(0, plan_height >= 2 ? plan_height - 2 : 0);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            blend_sequence();
         end else if (pick < 80) begin
            load_pixel($urandom_range(0, (1 << COL_BITS) - 1),
                       $urandom_range(0, (1 << ROW_BITS) - 1), random_pixel());
         end else begin
            outside_query();
         end
      end
   endtask

   task automatic test_reset_geometry();
      load_pixel(638, 478, 8'd0);
      load_pixel(639, 478, 8'd255);
      load_pixel(638, 479, 8'd128);
      load_pixel(639, 479, 8'd1);
      query_at((638 << FRAC_BITS) + 128, (478 << FRAC_BITS) + 64);
      query_at(639 << FRAC_BITS, 478 << FRAC_BITS);
      query_at(638 << FRAC_BITS, 479 << FRAC_BITS);
   endtask

   task automatic test_full_frame_edges();
      set_geometry(int'(MAX_COLS), int'(MAX_ROWS));
      load_pixel(1022, 510, 8'd255);
      load_pixel(1023, 510, 8'd255);
      load_pixel(1022, 511, 8'd255);
      load_pixel(1023, 511, 8'd255);
      query_at(((1 << COL_BITS) - 2 << FRAC_BITS) | FRAC_MASK,
               ((1 << ROW_BITS) - 2 << FRAC_BITS) | FRAC_MASK);
      query_at((1 << QX_BITS) - 1, (1 << QY_BITS) - 1);
      load_pixel(0, 0, 8'd0);
      load_pixel(1, 0, 8'd0);
      load_pixel(0, 1, 8'd0);
      load_pixel(1, 1, 8'd0);
      query_at(0, 0);
   endtask

   task automatic test_size_limits();
      set_geometry(1, int'(MAX_ROWS));
      query_at(0, 0);
      set_geometry(int'(MAX_COLS), 0);
      query_at(0, 0);
      set_geometry((1 << WIDTH_BITS) - 1, (1 << HEIGHT_BITS) - 1);
      query_at(((1 << COL_BITS) - 2 << FRAC_BITS) | FRAC_MASK,
               ((1 << ROW_BITS) - 2 << FRAC_BITS) | FRAC_MASK);
      set_geometry(2, 2);
      query_at(1 << (FRAC_BITS - 1), 1 << (FRAC_BITS - 1));
      query_at(1 << FRAC_BITS, 0);
   endtask

   task automatic test_random_traffic();
      run_phase(int'(MAX_COLS), int'(MAX_ROWS));
      run_phase(int'(WIDTH_RESET), int'(HEIGHT_RESET));
      run_phase(2, 2);
      run_phase($urandom_range(2, 1024), $urandom_range(2, 512));
      run_phase($urandom_range(1025, 2047), $urandom_range(513, 1023));
      run_phase($urandom_range(0, 1), $urandom_range(0, 2047));
      run_phase($urandom_range(2, 16), $urandom_range(2, 16));
      run_phase($urandom_range(2, 1024), $urandom_range(0, 2047));
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_geometry();
      test_full_frame_edges();
      test_size_limits();
      test_random_traffic();
      settle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/bis_pkg.sv
design/bis_frame_bank.sv
design/bis_frame_store.sv
design/bis_blend.sv
design/bilinear_image_sampler_top.sv
test/testbench.sv
